// ===== sv/bitmap_block_allocator_macros.svh =====
// Assertion helpers used by the allocator RTL.
`ifndef BITMAP_BLOCK_ALLOCATOR_MACROS_SVH
`define BITMAP_BLOCK_ALLOCATOR_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted
`define BBA_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted
`define BBA_ASSERT_NXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== sv/bba_pkg.sv =====
package bba_pkg;

    // Geometry of the bitmap
    localparam int MAX_BLOCKS = 65536;
    localparam int WORD_BITS  = 64;
    localparam int NUM_WORDS  = (MAX_BLOCKS + WORD_BITS - 1) / WORD_BITS;
    localparam int WIDX_W     = $clog2(WORD_BITS);
    localparam int ADDR_W     = $clog2(NUM_WORDS);

    // Field widths
    localparam int COUNT_W = 17;
    localparam int BLK_W   = 16;
    localparam int WN_W    = COUNT_W - WIDX_W;

    typedef logic [WORD_BITS-1:0] word_t;
    typedef logic [COUNT_W-1:0]   count_t;
    typedef logic [WN_W-1:0]      wnum_t;
    typedef logic [WIDX_W-1:0]    widx_t;
    typedef logic [ADDR_W-1:0]    addr_t;

    localparam count_t COUNT_MAX = '1;

    // Operation codes
    typedef enum logic [1:0] {
        OP_ALLOC  = 2'd0,
        OP_FREE   = 2'd1,
        OP_TEST   = 2'd2,
        OP_FORMAT = 2'd3
    } op_t;

    // Status codes
    localparam logic [1:0] STS_OK           = 2'd0;
    localparam logic [1:0] STS_NO_FREE      = 2'd1;
    localparam logic [1:0] STS_RANGE        = 2'd2;
    localparam logic [1:0] STS_ALREADY_FREE = 2'd3;

    // Configuration register indexes
    localparam logic [1:0] CFG_TOTAL    = 2'd0;
    localparam logic [1:0] CFG_RESERVED = 2'd1;

    // Free-bit search result
    typedef struct packed {
        logic  hit;
        widx_t idx;
    } find_t;

    // Bits of word w whose block number lies below n
    function automatic word_t low_mask(wnum_t w, count_t n);
        wnum_t lim;
        widx_t part;
        word_t m;
        lim  = wnum_t'(n >> WIDX_W);
        part = n[WIDX_W-1:0];
        if (w < lim) begin
            m = '1;
        end else if (w == lim) begin
            m = (word_t'(1) << part) - word_t'(1);
        end else begin
            m = '0;
        end
        return m;
    endfunction

endpackage

// ===== sv/bba_find.sv =====
// Lowest free bit of one bitmap word, limited to the managed blocks
module bba_find (
    input  bba_pkg::word_t data,
    input  bba_pkg::word_t valid_mask,
    output bba_pkg::find_t res
);
    import bba_pkg::*;

    word_t free_bits;
    word_t lowest;
    widx_t idx;

    // isolate the lowest set bit of the free set
    assign free_bits = ~data & valid_mask;
    assign lowest    = free_bits & (~free_bits + word_t'(1));

    // encode its position
    always_comb begin
        idx = '0;
        for (int i = 0; i < WORD_BITS; i++) begin
            if (lowest[i]) begin
                idx = idx | widx_t'(i);
            end
        end
    end

    assign res = {|free_bits, idx};

endmodule

// ===== sv/bitmap_block_allocator.sv =====
// First-fit block allocator over a used/free bitmap held in a 1024 x 64 RAM.
// Input channel s_*: one beat carries an op (allocate, free, test, format)
// and a block number. Result channel m_*: one beat per op with status,
// block number, tested bit and the free count after the op.
// Config channel cfg_*: index 0 total_blocks, index 1 reserved_blocks;
// always ready; it is to be written only while the block is idle, which the block does not enforce.
// One op is processed at a time; s_ready is high only when idle.
// Steps of each op after it is accepted:
//   free / test      : RAM read on accept, check, output load
//   allocate         : words scanned from word 0 up to the first word
//                      with a free bit; one RAM word is read per cycle
//   allocate, none   : no scan when the count is zero, else all managed words
//   format           : every RAM word rewritten, one RAM word per cycle
// After reset the RAM is cleared in a pass over all 1024 words with s_ready low;
// the free count is zero until the first format.
// The result sits in an output register; if m_ready is low it waits there,
// the next op is still accepted and run, and its result is held in the
// sequencer until the waiting beat goes out.
`include "bitmap_block_allocator_macros.svh"

module bitmap_block_allocator (
    input  logic        aclk,
    input  logic        aresetn,
    // config write
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [16:0] cfg_data,
    // op input
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [1:0]  s_op,
    input  logic [15:0] s_block_number,
    // result output
    output logic        m_valid,
    input  logic        m_ready,
    output logic [1:0]  m_status,
    output logic [15:0] m_result_block,
    output logic        m_bit_value,
    output logic [16:0] m_free_count
);
    import bba_pkg::*;

    typedef enum logic [5:0] {
        S_CLEAR    = 6'b000001,
        S_IDLE     = 6'b000010,
        S_SCAN     = 6'b000100,
        S_ALLOC_WR = 6'b001000,
        S_CHK      = 6'b010000,
        S_OUT      = 6'b100000
    } state_t;

    // bitmap storage
    word_t mem [NUM_WORDS];

    state_t            state_reg, state_next;
    count_t            total_reg, reserved_reg;
    count_t            count_reg, count_next;
    count_t            size_reg, size_next;
    count_t            rsv_reg, rsv_next;
    wnum_t             words_reg, words_next;
    op_t               op_reg, op_next;
    logic [BLK_W-1:0]  blk_reg, blk_next;
    wnum_t             scan_reg, scan_next;
    logic              rdv_reg, rdv_next;
    wnum_t             rdw_reg, rdw_next;
    word_t             rdata_reg;
    wnum_t             hitw_reg, hitw_next;
    widx_t             hitb_reg, hitb_next;
    word_t             word_reg, word_next;
    addr_t             clr_reg, clr_next;
    logic              fmt_reg, fmt_next;
    logic [1:0]        res_status_reg, res_status_next;
    logic [BLK_W-1:0]  res_blk_reg, res_blk_next;
    logic              res_bit_reg, res_bit_next;
    logic              m_valid_reg, m_valid_next;
    logic [1:0]        m_status_reg;
    logic [BLK_W-1:0]  m_blk_reg;
    logic              m_bit_reg;
    count_t            m_count_reg;

    logic    mem_we;
    addr_t   mem_waddr, mem_raddr;
    word_t   mem_wdata;
    count_t  size_c, rsv_c;
    logic    in_range, issue, clr_last, chk_bit, out_load;
    find_t   find_res;
    widx_t   blk_bit;

    // effective size and clamped reserved prefix
    assign size_c   = (total_reg > count_t'(MAX_BLOCKS)) ? count_t'(MAX_BLOCKS) : total_reg;
    assign rsv_c    = (reserved_reg > size_c) ? size_c : reserved_reg;
    assign in_range = {1'b0, s_block_number} < size_c;
    assign issue    = scan_reg < words_reg;
    assign clr_last = clr_reg == addr_t'(NUM_WORDS - 1);
    assign blk_bit  = blk_reg[WIDX_W-1:0];
    assign chk_bit  = rdata_reg[blk_bit];
    assign out_load = (state_reg == S_OUT) && (!m_valid_reg || m_ready);

    assign s_ready   = state_reg == S_IDLE;
    assign cfg_ready = 1'b1;

    // free-bit search on the word read last cycle
    bba_find u_find (
        .data       (rdata_reg),
        .valid_mask (low_mask(rdw_reg, size_reg)),
        .res        (find_res)
    );

    // bitmap RAM: one write and one registered read port
    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[mem_waddr] <= mem_wdata;
        end
        rdata_reg <= mem[mem_raddr];
    end

    // read address: block word on accept, scan pointer otherwise
    always_comb begin
        if (state_reg == S_IDLE) begin
            mem_raddr = addr_t'(s_block_number >> WIDX_W);
        end else begin
            mem_raddr = scan_reg[ADDR_W-1:0];
        end
    end

    // sequencer
    always_comb begin
        state_next      = state_reg;
        count_next      = count_reg;
        size_next       = size_reg;
        rsv_next        = rsv_reg;
        words_next      = words_reg;
        op_next         = op_reg;
        blk_next        = blk_reg;
        scan_next       = scan_reg;
        rdv_next        = 1'b0;
        rdw_next        = scan_reg;
        hitw_next       = hitw_reg;
        hitb_next       = hitb_reg;
        word_next       = word_reg;
        clr_next        = clr_reg;
        fmt_next        = fmt_reg;
        res_status_next = res_status_reg;
        res_blk_next    = res_blk_reg;
        res_bit_next    = res_bit_reg;
        m_valid_next    = m_valid_reg && !m_ready;
        mem_we          = 1'b0;
        mem_waddr       = clr_reg;
        mem_wdata       = low_mask(wnum_t'(clr_reg), rsv_reg);

        unique case (state_reg)
            S_CLEAR: begin
                mem_we   = 1'b1;
                clr_next = clr_reg + addr_t'(1);
                if (clr_last) begin
                    if (fmt_reg) begin
                        count_next      = size_reg - rsv_reg;
                        res_status_next = STS_OK;
                        res_blk_next    = '0;
                        res_bit_next    = 1'b0;
                        state_next      = S_OUT;
                    end else begin
                        state_next = S_IDLE;
                    end
                end
            end
            S_IDLE: begin
                if (s_valid) begin
                    op_next         = op_t'(s_op);
                    blk_next        = s_block_number;
                    size_next       = size_c;
                    rsv_next        = rsv_c;
                    words_next      = wnum_t'((size_c + count_t'(WORD_BITS - 1)) >> WIDX_W);
                    res_blk_next    = s_block_number;
                    res_bit_next    = 1'b0;
                    res_status_next = STS_OK;
                    unique case (op_t'(s_op))
                        OP_ALLOC: begin
                            res_blk_next = '0;
                            scan_next    = '0;
                            if (count_reg == '0) begin
                                res_status_next = STS_NO_FREE;
                                state_next      = S_OUT;
                            end else begin
                                state_next = S_SCAN;
                            end
                        end
                        OP_FREE, OP_TEST: begin
                            if (in_range) begin
                                state_next = S_CHK;
                            end else begin
                                res_status_next = STS_RANGE;
                                state_next      = S_OUT;
                            end
                        end
                        OP_FORMAT: begin
                            res_blk_next = '0;
                            clr_next     = '0;
                            fmt_next     = 1'b1;
                            state_next   = S_CLEAR;
                        end
                        default: begin
                            state_next = S_IDLE;
                        end
                    endcase
                end
            end
            S_SCAN: begin
                // one word issued per cycle, checked the cycle after
                if (rdv_reg && find_res.hit) begin
                    hitw_next  = rdw_reg;
                    hitb_next  = find_res.idx;
                    word_next  = rdata_reg;
                    state_next = S_ALLOC_WR;
                end else if (!rdv_reg && !issue) begin
                    res_status_next = STS_NO_FREE;
                    state_next      = S_OUT;
                end else begin
                    rdv_next = issue;
                    if (issue) begin
                        scan_next = scan_reg + wnum_t'(1);
                    end
                end
            end
            S_ALLOC_WR: begin
                mem_we       = 1'b1;
                mem_waddr    = hitw_reg[ADDR_W-1:0];
                mem_wdata    = word_reg | (word_t'(1) << hitb_reg);
                count_next   = count_reg - count_t'(1);
                res_blk_next = BLK_W'({hitw_reg, hitb_reg});
                state_next   = S_OUT;
            end
            S_CHK: begin
                mem_waddr  = addr_t'(blk_reg >> WIDX_W);
                mem_wdata  = rdata_reg & ~(word_t'(1) << blk_bit);
                state_next = S_OUT;
                if (op_reg == OP_TEST) begin
                    res_bit_next = chk_bit;
                end else if (!chk_bit) begin
                    res_status_next = STS_ALREADY_FREE;
                end else begin
                    mem_we     = 1'b1;
                    count_next = (count_reg == COUNT_MAX) ? count_reg
                                                          : count_reg + count_t'(1);
                end
            end
            S_OUT: begin
                if (out_load) begin
                    m_valid_next = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_CLEAR;
            clr_reg      <= '0;
            fmt_reg      <= 1'b0;
            rsv_reg      <= '0;
            count_reg    <= '0;
            rdv_reg      <= 1'b0;
            m_valid_reg  <= 1'b0;
            total_reg    <= count_t'(MAX_BLOCKS);
            reserved_reg <= count_t'(1);
        end else begin
            state_reg   <= state_next;
            clr_reg     <= clr_next;
            fmt_reg     <= fmt_next;
            rsv_reg     <= rsv_next;
            count_reg   <= count_next;
            rdv_reg     <= rdv_next;
            m_valid_reg <= m_valid_next;
            if (cfg_valid) begin
                unique case (cfg_index)
                    CFG_TOTAL:    total_reg    <= cfg_data;
                    CFG_RESERVED: reserved_reg <= cfg_data;
                    default: begin
                    end
                endcase
            end
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        size_reg       <= size_next;
        words_reg      <= words_next;
        op_reg         <= op_next;
        blk_reg        <= blk_next;
        scan_reg       <= scan_next;
        rdw_reg        <= rdw_next;
        hitw_reg       <= hitw_next;
        hitb_reg       <= hitb_next;
        word_reg       <= word_next;
        res_status_reg <= res_status_next;
        res_blk_reg    <= res_blk_next;
        res_bit_reg    <= res_bit_next;
        if (out_load) begin
            m_status_reg <= res_status_reg;
            m_blk_reg    <= res_blk_reg;
            m_bit_reg    <= res_bit_reg;
            m_count_reg  <= count_reg;
        end
    end

    assign m_valid        = m_valid_reg;
    assign m_status       = m_status_reg;
    assign m_result_block = m_blk_reg;
    assign m_bit_value    = m_bit_reg;
    assign m_free_count   = m_count_reg;

    // checks
    `BBA_ASSERT_IMP(a_alloc_in_range, aclk, aresetn,
        state_reg == S_ALLOC_WR, ({hitw_reg, hitb_reg} < size_reg) && (count_reg != '0),
        "allocated block outside managed range or with zero count")
    `BBA_ASSERT_NXT(a_format_count, aclk, aresetn,
        (state_reg == S_CLEAR) && fmt_reg && clr_last, count_reg <= size_reg,
        "format count exceeds managed size")
    `BBA_ASSERT_IMP(a_out_from_final, aclk, aresetn,
        $rose(m_valid_reg), $past(state_reg) == S_OUT,
        "result beat raised outside the output state")

endmodule
